// File: rtl/lob_pkg.sv
// shared constants, codes and types of the order book engine
`default_nettype none
package lob_pkg;
   localparam int ORDER_SLOTS = 1024;
   localparam int LEVEL_SLOTS = 256;
   localparam int OIDX_W = $clog2(ORDER_SLOTS);
   localparam int LIDX_W = $clog2(LEVEL_SLOTS);
   localparam int CNT_W = $clog2(ORDER_SLOTS + 1);
   localparam int SCAN_N = (ORDER_SLOTS > LEVEL_SLOTS) ? ORDER_SLOTS : LEVEL_SLOTS;
   localparam int SCAN_W = $clog2(SCAN_N + 1);
   localparam int FLAG_W = 2;
   localparam int FLAG_VALID = 0;
   localparam int FLAG_SELL = 1;
   localparam int REQ_DATA_W = 200;
   localparam int RSP_DATA_W = 168;

   typedef enum logic [1:0] {
      ACT_ADD     = 2'd0,
      ACT_REDUCE  = 2'd1,
      ACT_DELETE  = 2'd2,
      ACT_REPLACE = 2'd3
   } act_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_DUPLICATE = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      act_type     action;
      logic        place;
      logic [63:0] order_ref;
      logic [63:0] new_ref;
      logic        side;
      logic [31:0] share_count;
      logic [31:0] limit_price;
   } item_type;
endpackage
`default_nettype wire

// File: rtl/lob_front.sv
// input side: unpacks and classifies words into a two-entry queue
`default_nettype none
module lob_front (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [lob_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire logic [1:0]                        req_tuser,
   input  wire logic                              clearing,
   output logic                                   item_valid,
   input  wire logic                              item_ready,
   output lob_pkg::item_type                      item
);
   lob_pkg::item_type q_ff [2];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic push, pop;
   lob_pkg::item_type word;

   always_comb begin
      word.action      = lob_pkg::act_type'(req_tuser);
      word.place       = (lob_pkg::act_type'(req_tuser) == lob_pkg::ACT_ADD);
      word.order_ref   = req_tdata[63:0];
      word.new_ref     = req_tdata[127:64];
      word.side        = req_tdata[128];
      word.share_count = req_tdata[160:129];
      word.limit_price = req_tdata[192:161];
   end

   assign req_tready = (fill_ff != 2'd2) && !clearing;
   assign item_valid = (fill_ff != 2'd0);
   assign item = q_ff[rd_ptr_ff];
   assign push = req_tvalid && req_tready;
   assign pop = item_valid && item_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= word;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
   end
endmodule
`default_nettype wire

// File: rtl/lob_engine.sv
// back end: order and level tables, scan sequencer and result register
`default_nettype none
module lob_engine (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              item_valid,
   output logic                                   item_ready,
   input  wire lob_pkg::item_type                 item,
   output logic                                   clearing,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [lob_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   output logic [1:0]                             rsp_tuser
);
   localparam int OW = lob_pkg::OIDX_W;
   localparam int LW = lob_pkg::LIDX_W;
   localparam int CW = lob_pkg::CNT_W;
   localparam int SW = lob_pkg::SCAN_W;
   localparam int FW = lob_pkg::FLAG_W;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_OSCAN, S_LSCAN, S_PLACE, S_DROP, S_BSCAN, S_RESULT
   } state_type;

   // tables
   logic [63:0]  ord_key_mem   [lob_pkg::ORDER_SLOTS];
   logic [FW-1:0] ord_flag_mem [lob_pkg::ORDER_SLOTS];
   logic [31:0]  ord_size_mem  [lob_pkg::ORDER_SLOTS];
   logic [31:0]  ord_price_mem [lob_pkg::ORDER_SLOTS];
   logic [FW-1:0] lvl_flag_mem [lob_pkg::LEVEL_SLOTS];
   logic [31:0]  lvl_price_mem [lob_pkg::LEVEL_SLOTS];
   logic [31:0]  lvl_vol_mem   [lob_pkg::LEVEL_SLOTS];
   logic [CW-1:0] lvl_cnt_mem  [lob_pkg::LEVEL_SLOTS];

   logic [63:0] ord_key_q;
   logic [FW-1:0] ord_flag_q;
   logic [31:0] ord_size_q, ord_price_q;
   logic [FW-1:0] lvl_flag_q;
   logic [31:0] lvl_price_q, lvl_vol_q;
   logic [CW-1:0] lvl_cnt_q;

   logic ord_we, lvl_we;
   logic [OW-1:0] ord_waddr;
   logic [LW-1:0] lvl_waddr;
   logic [63:0] ord_wkey;
   logic [FW-1:0] ord_wflag, lvl_wflag;
   logic [31:0] ord_wsize, ord_wprice, lvl_wprice, lvl_wvol;
   logic [CW-1:0] lvl_wcnt;

   state_type state_ff, state_in;
   logic [SW-1:0] cnt_ff, cnt_in;
   logic chk_v_ff, chk_v_in;
   logic [SW-1:0] chk_idx_ff, chk_idx_in;
   lob_pkg::item_type item_ff, item_in;
   logic [63:0] tkey_ff, tkey_in;
   logic tside_ff, tside_in;
   logic [31:0] tprice_ff, tprice_in;
   logic place_ff, place_in;
   logic ofound_ff, ofound_in;
   logic [OW-1:0] oidx_ff, oidx_in;
   logic [31:0] osize_ff, osize_in, oprice_ff, oprice_in;
   logic oside_ff, oside_in;
   logic ofree_ff, ofree_in;
   logic [OW-1:0] ofree_idx_ff, ofree_idx_in;
   logic lfound_ff, lfound_in;
   logic [LW-1:0] lidx_ff, lidx_in;
   logic [31:0] lvol_ff, lvol_in;
   logic [CW-1:0] lcnt_ff, lcnt_in;
   logic lfree_ff, lfree_in;
   logic [LW-1:0] lfree_idx_ff, lfree_idx_in;
   logic bid_v_ff, bid_v_in, ask_v_ff, ask_v_in;
   logic [31:0] bid_ff, bid_in, bvol_ff, bvol_in, ask_ff, ask_in, avol_ff, avol_in;
   lob_pkg::status_type status_ff, status_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [lob_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [1:0] rsp_user_ff, rsp_user_in;

   logic [SW-1:0] scan_len;
   logic scan_end;
   logic [32:0] vol_sum;
   logic [31:0] base_vol, cut, new_size, dec_vol;
   logic [CW-1:0] base_cnt, dec_cnt, new_cnt;
   logic drop;
   logic [32:0] spread;

   assign clearing = (state_ff == S_CLEAR);
   assign item_ready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

   always_comb begin
      unique case (state_ff)
         S_OSCAN: scan_len = SW'(lob_pkg::ORDER_SLOTS);
         S_LSCAN, S_BSCAN: scan_len = SW'(lob_pkg::LEVEL_SLOTS);
         default: scan_len = SW'(lob_pkg::SCAN_N);
      endcase
   end
   assign scan_end = (cnt_ff == scan_len) && !chk_v_ff;

   // arithmetic for placing and removing shares
   assign base_vol = lfound_ff ? lvol_ff : 32'd0;
   assign base_cnt = lfound_ff ? lcnt_ff : '0;
   assign vol_sum = {1'b0, base_vol} + {1'b0, item_ff.share_count};
   assign cut = (item_ff.action == lob_pkg::ACT_REDUCE && item_ff.share_count < osize_ff)
                ? item_ff.share_count : osize_ff;
   assign new_size = osize_ff - cut;
   assign drop = (new_size == 32'd0);
   assign dec_vol = (lvol_ff > cut) ? lvol_ff - cut : 32'd0;
   assign dec_cnt = (lcnt_ff != '0) ? lcnt_ff - CW'(1) : '0;
   assign new_cnt = drop ? dec_cnt : lcnt_ff;
   assign spread = (bid_v_ff && ask_v_ff) ? ({1'b0, ask_ff} - {1'b0, bid_ff}) : 33'd0;

   // table write ports
   always_comb begin
      ord_we = 1'b0;
      ord_waddr = cnt_ff[OW-1:0];
      ord_wkey = tkey_ff;
      ord_wflag = '0;
      ord_wsize = new_size;
      ord_wprice = oprice_ff;
      lvl_we = 1'b0;
      lvl_waddr = cnt_ff[LW-1:0];
      lvl_wflag = '0;
      lvl_wprice = tprice_ff;
      lvl_wvol = dec_vol;
      lvl_wcnt = new_cnt;
      unique case (state_ff)
         S_CLEAR: begin
            ord_we = (cnt_ff < SW'(lob_pkg::ORDER_SLOTS));
            lvl_we = (cnt_ff < SW'(lob_pkg::LEVEL_SLOTS));
         end
         S_PLACE: begin
            ord_we = 1'b1;
            ord_waddr = ofree_idx_ff;
            ord_wflag = {tside_ff, 1'b1};
            ord_wsize = item_ff.share_count;
            ord_wprice = tprice_ff;
            lvl_we = lfound_ff || lfree_ff;
            lvl_waddr = lfound_ff ? lidx_ff : lfree_idx_ff;
            lvl_wflag = {tside_ff, 1'b1};
            lvl_wvol = vol_sum[32] ? 32'hFFFF_FFFF : vol_sum[31:0];
            lvl_wcnt = base_cnt + CW'(1);
         end
         S_DROP: begin
            ord_we = 1'b1;
            ord_waddr = oidx_ff;
            ord_wflag = drop ? '0 : {oside_ff, 1'b1};
            lvl_we = lfound_ff;
            lvl_waddr = lidx_ff;
            lvl_wflag = (drop && new_cnt == '0) ? '0 : {tside_ff, 1'b1};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ord_we) begin
         ord_key_mem[ord_waddr] <= ord_wkey;
         ord_flag_mem[ord_waddr] <= ord_wflag;
         ord_size_mem[ord_waddr] <= ord_wsize;
         ord_price_mem[ord_waddr] <= ord_wprice;
      end
      ord_key_q <= ord_key_mem[cnt_ff[OW-1:0]];
      ord_flag_q <= ord_flag_mem[cnt_ff[OW-1:0]];
      ord_size_q <= ord_size_mem[cnt_ff[OW-1:0]];
      ord_price_q <= ord_price_mem[cnt_ff[OW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (lvl_we) begin
         lvl_flag_mem[lvl_waddr] <= lvl_wflag;
         lvl_price_mem[lvl_waddr] <= lvl_wprice;
         lvl_vol_mem[lvl_waddr] <= lvl_wvol;
         lvl_cnt_mem[lvl_waddr] <= lvl_wcnt;
      end
      lvl_flag_q <= lvl_flag_mem[cnt_ff[LW-1:0]];
      lvl_price_q <= lvl_price_mem[cnt_ff[LW-1:0]];
      lvl_vol_q <= lvl_vol_mem[cnt_ff[LW-1:0]];
      lvl_cnt_q <= lvl_cnt_mem[cnt_ff[LW-1:0]];
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      chk_v_in = 1'b0;
      chk_idx_in = cnt_ff;
      item_in = item_ff;
      tkey_in = tkey_ff;
      tside_in = tside_ff;
      tprice_in = tprice_ff;
      place_in = place_ff;
      ofound_in = ofound_ff;
      oidx_in = oidx_ff;
      osize_in = osize_ff;
      oprice_in = oprice_ff;
      oside_in = oside_ff;
      ofree_in = ofree_ff;
      ofree_idx_in = ofree_idx_ff;
      lfound_in = lfound_ff;
      lidx_in = lidx_ff;
      lvol_in = lvol_ff;
      lcnt_in = lcnt_ff;
      lfree_in = lfree_ff;
      lfree_idx_in = lfree_idx_ff;
      bid_v_in = bid_v_ff;
      bid_in = bid_ff;
      bvol_in = bvol_ff;
      ask_v_in = ask_v_ff;
      ask_in = ask_ff;
      avol_in = avol_ff;
      status_in = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;

      // one table entry per cycle; read data is registered and arrives in the cycle after its address
      if ((state_ff == S_OSCAN || state_ff == S_LSCAN || state_ff == S_BSCAN)
          && cnt_ff != scan_len) begin
         cnt_in = cnt_ff + SW'(1);
         chk_v_in = 1'b1;
      end

      unique case (state_ff)
         S_CLEAR: begin
            cnt_in = cnt_ff + SW'(1);
            if (cnt_ff == SW'(lob_pkg::SCAN_N)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (item_valid) begin
               item_in = item;
               tkey_in = item.order_ref;
               tside_in = item.side;
               tprice_in = item.limit_price;
               place_in = item.place;
               status_in = lob_pkg::ST_OK;
               ofound_in = 1'b0;
               ofree_in = 1'b0;
               cnt_in = '0;
               state_in = S_OSCAN;
            end
         end
         S_OSCAN: begin
            if (chk_v_ff) begin
               if (ord_flag_q[lob_pkg::FLAG_VALID] && ord_key_q == tkey_ff && !ofound_ff) begin
                  ofound_in = 1'b1;
                  oidx_in = chk_idx_ff[OW-1:0];
                  osize_in = ord_size_q;
                  oprice_in = ord_price_q;
                  oside_in = ord_flag_q[lob_pkg::FLAG_SELL];
               end
               if (!ord_flag_q[lob_pkg::FLAG_VALID] && !ofree_ff) begin
                  ofree_in = 1'b1;
                  ofree_idx_in = chk_idx_ff[OW-1:0];
               end
            end
            if (scan_end) begin
               cnt_in = '0;
               lfound_in = 1'b0;
               lfree_in = 1'b0;
               bid_v_in = 1'b0;
               ask_v_in = 1'b0;
               state_in = S_LSCAN;
               if (place_ff) begin
                  if (ofound_ff) begin
                     status_in = lob_pkg::ST_DUPLICATE;
                     state_in = S_BSCAN;
                  end else if (!ofree_ff) begin
                     status_in = lob_pkg::ST_FULL;
                     state_in = S_BSCAN;
                  end
               end else if (!ofound_ff) begin
                  status_in = lob_pkg::ST_NOT_FOUND;
                  state_in = S_BSCAN;
               end else begin
                  tside_in = oside_ff;
                  tprice_in = oprice_ff;
               end
            end
         end
         S_LSCAN: begin
            if (chk_v_ff) begin
               if (lvl_flag_q[lob_pkg::FLAG_VALID] && lvl_flag_q[lob_pkg::FLAG_SELL] == tside_ff
                   && lvl_price_q == tprice_ff && !lfound_ff) begin
                  lfound_in = 1'b1;
                  lidx_in = chk_idx_ff[LW-1:0];
                  lvol_in = lvl_vol_q;
                  lcnt_in = lvl_cnt_q;
               end
               if (!lvl_flag_q[lob_pkg::FLAG_VALID] && !lfree_ff) begin
                  lfree_in = 1'b1;
                  lfree_idx_in = chk_idx_ff[LW-1:0];
               end
            end
            if (scan_end) begin
               if (!place_ff) begin
                  state_in = S_DROP;
               end else if (lfound_ff || lfree_ff) begin
                  state_in = S_PLACE;
               end else begin
                  status_in = lob_pkg::ST_FULL;
                  cnt_in = '0;
                  state_in = S_BSCAN;
               end
            end
         end
         S_PLACE: begin
            status_in = lob_pkg::ST_OK;
            cnt_in = '0;
            state_in = S_BSCAN;
         end
         S_DROP: begin
            cnt_in = '0;
            if (item_ff.action == lob_pkg::ACT_REPLACE) begin
               // second half of a replace: add under the new reference, old side kept
               place_in = 1'b1;
               tkey_in = item_ff.new_ref;
               tprice_in = item_ff.limit_price;
               ofound_in = 1'b0;
               ofree_in = 1'b0;
               state_in = S_OSCAN;
            end else begin
               state_in = S_BSCAN;
            end
         end
         S_BSCAN: begin
            if (chk_v_ff && lvl_flag_q[lob_pkg::FLAG_VALID]) begin
               if (lvl_flag_q[lob_pkg::FLAG_SELL]) begin
                  if (!ask_v_ff || lvl_price_q < ask_ff) begin
                     ask_v_in = 1'b1;
                     ask_in = lvl_price_q;
                     avol_in = lvl_vol_q;
                  end
               end else begin
                  if (!bid_v_ff || lvl_price_q > bid_ff) begin
                     bid_v_in = 1'b1;
                     bid_in = lvl_price_q;
                     bvol_in = lvl_vol_q;
                  end
               end
            end
            if (scan_end) begin
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in = status_ff;
               rsp_data_in = {7'd0, spread,
                              ask_v_ff ? avol_ff : 32'd0, bid_v_ff ? bvol_ff : 32'd0,
                              ask_v_ff ? ask_ff : 32'd0, bid_v_ff ? bid_ff : 32'd0};
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // empty sides clear at the start of every best-price pass
      if (state_in == S_BSCAN && state_ff != S_BSCAN) begin
         bid_v_in = 1'b0;
         ask_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff <= chk_idx_in;
      item_ff <= item_in;
      tkey_ff <= tkey_in;
      tside_ff <= tside_in;
      tprice_ff <= tprice_in;
      place_ff <= place_in;
      ofound_ff <= ofound_in;
      oidx_ff <= oidx_in;
      osize_ff <= osize_in;
      oprice_ff <= oprice_in;
      oside_ff <= oside_in;
      ofree_ff <= ofree_in;
      ofree_idx_ff <= ofree_idx_in;
      lfound_ff <= lfound_in;
      lidx_ff <= lidx_in;
      lvol_ff <= lvol_in;
      lcnt_ff <= lcnt_in;
      lfree_ff <= lfree_in;
      lfree_idx_ff <= lfree_idx_in;
      bid_v_ff <= bid_v_in;
      bid_ff <= bid_in;
      bvol_ff <= bvol_in;
      ask_v_ff <= ask_v_in;
      ask_ff <= ask_in;
      avol_ff <= avol_in;
      status_ff <= status_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff <= '0;
         chk_v_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         chk_v_ff <= chk_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule
`default_nettype wire

// File: rtl/limit_order_book_engine.sv
// top level of the single-symbol limit order book
//
//   group   dir   tdata (lsb first)                                  tuser
//   req_    in    order_ref, new_ref, side, share_count, limit_price action
//   rsp_    out   best_bid_price, best_ask_price, best_bid_volume,   status
//                 best_ask_volume, spread_ticks
//
// add, reduce and delete make one pass over the order table, one level lookup pass and one
// best-price pass; a duplicate, an unknown reference or a full order table skips the lookup.
// replace adds a second order pass and level pass. one table entry is read per cycle.
// after reset a clearing pass over both tables runs first, with req_tready low. a two-word
// queue sits in front of the sequencer and the result register lets the next word start
// while a result waits on rsp_tready.
`default_nettype none
module limit_order_book_engine (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // order_ref[63:0], new_ref[127:64], side[128], share_count[160:129],
   // limit_price[192:161], zero above
   input  wire logic [lob_pkg::REQ_DATA_W-1:0]    req_tdata,
   // action[1:0]
   input  wire logic [1:0]                        req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // best_bid_price[31:0], best_ask_price[63:32], best_bid_volume[95:64],
   // best_ask_volume[127:96], spread_ticks[160:128], zero above
   output logic [lob_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   // status[1:0]
   output logic [1:0]                             rsp_tuser
);
   logic item_valid, item_ready, clearing;
   lob_pkg::item_type item;

   lob_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .clearing   (clearing),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item)
   );

   lob_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item),
      .clearing   (clearing),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );
endmodule
`default_nettype wire

// File: bench/tb_limit_order_book_engine.sv
// self-checking testbench of the limit order book engine
`timescale 1ns / 100ps
`default_nettype none
module tb_limit_order_book_engine;
   import lob_pkg::*;

   typedef struct {
      status_type  status;
      bit [31:0]   bid;
      bit [31:0]   ask;
      bit [31:0]   bid_vol;
      bit [31:0]   ask_vol;
      bit [32:0]   spread;
   } book_view;

   class book_scoreboard;
      bit [63:0] okey   [ORDER_SLOTS];
      bit        ovalid [ORDER_SLOTS];
      bit        osell  [ORDER_SLOTS];
      bit [31:0] osize  [ORDER_SLOTS];
      bit [31:0] oprice [ORDER_SLOTS];
      bit        lvalid [LEVEL_SLOTS];
      bit        lsell  [LEVEL_SLOTS];
      bit [31:0] lprice [LEVEL_SLOTS];
      bit [31:0] lvol   [LEVEL_SLOTS];
      int        lcount [LEVEL_SLOTS];
      book_view  pending [$];
      int        errors;

      function int find_order(bit [63:0] oref);
         for (int i = 0; i < ORDER_SLOTS; i++)
            if (ovalid[i] && okey[i] == oref) return i;
         return -1;
      endfunction

      function int find_level(bit sell, bit [31:0] price);
         for (int i = 0; i < LEVEL_SLOTS; i++)
            if (lvalid[i] && lsell[i] == sell && lprice[i] == price) return i;
         return -1;
      endfunction

      function void retire_entry(int o);
         int l;
         l = find_level(osell[o], oprice[o]);
         if (l >= 0) begin
            lvol[l] = (lvol[l] > osize[o]) ? lvol[l] - osize[o] : 0;
            if (lcount[l] > 0) lcount[l]--;
            if (lcount[l] == 0) lvalid[l] = 0;
         end
         ovalid[o] = 0;
      endfunction

      function status_type place(bit [63:0] oref, bit sell, bit [31:0] shares,
                                 bit [31:0] price);
         int o;
         int l;
         if (find_order(oref) >= 0) return ST_DUPLICATE;
         o = -1;
         for (int i = 0; i < ORDER_SLOTS && o < 0; i++)
            if (!ovalid[i]) o = i;
         if (o < 0) return ST_FULL;
         l = find_level(sell, price);
         if (l < 0) begin
            for (int i = 0; i < LEVEL_SLOTS && l < 0; i++)
               if (!lvalid[i]) l = i;
            if (l < 0) return ST_FULL;
            lvalid[l] = 1;
            lsell[l] = sell;
            lprice[l] = price;
            lvol[l] = 0;
            lcount[l] = 0;
         end
         lvol[l] = (lvol[l] > 32'hFFFF_FFFF - shares) ? 32'hFFFF_FFFF : lvol[l] + shares;
         lcount[l]++;
         okey[o] = oref;
         ovalid[o] = 1;
         osell[o] = sell;
         osize[o] = shares;
         oprice[o] = price;
         return ST_OK;
      endfunction

      // apply one accepted word and queue the book view it must produce
      function void note_order(act_type act, bit [63:0] oref, bit [63:0] nref, bit sell,
                               bit [31:0] shares, bit [31:0] price);
         book_view v;
         int o;
         int l;
         int bl;
         int al;
         bit [31:0] cut;
         bit keep;
         v.status = ST_OK;
         if (act == ACT_ADD) begin
            v.status = place(oref, sell, shares, price);
         end else begin
            o = find_order(oref);
            if (o < 0) begin
               v.status = ST_NOT_FOUND;
            end else if (act == ACT_REDUCE) begin
               cut = (shares < osize[o]) ? shares : osize[o];
               l = find_level(osell[o], oprice[o]);
               osize[o] -= cut;
               if (l >= 0) lvol[l] = (lvol[l] > cut) ? lvol[l] - cut : 0;
               if (osize[o] == 0) retire_entry(o);
            end else if (act == ACT_DELETE) begin
               retire_entry(o);
            end else begin
               keep = osell[o];
               retire_entry(o);
               v.status = place(nref, keep, shares, price);
            end
         end
         bl = -1;
         al = -1;
         for (int i = 0; i < LEVEL_SLOTS; i++) begin
            if (!lvalid[i]) continue;
            if (lsell[i]) begin
               if (al < 0 || lprice[i] < lprice[al]) al = i;
            end else begin
               if (bl < 0 || lprice[i] > lprice[bl]) bl = i;
            end
         end
         v.bid = (bl >= 0) ? lprice[bl] : 0;
         v.bid_vol = (bl >= 0) ? lvol[bl] : 0;
         v.ask = (al >= 0) ? lprice[al] : 0;
         v.ask_vol = (al >= 0) ? lvol[al] : 0;
         v.spread = (bl >= 0 && al >= 0) ? {1'b0, v.ask} - {1'b0, v.bid} : 0;
         pending.push_back(v);
      endfunction

      function void compare(string name, bit [32:0] exp_v, bit [32:0] got_v);
         if (exp_v !== got_v) begin
            $display("%0t %s mismatch: expected %0h actual %0h", $time, name, exp_v, got_v);
            errors++;
         end
      endfunction

      function void check_result(book_view got);
         book_view e;
         if (pending.size() == 0) begin
            $display("%0t unexpected result word, status %0d", $time, got.status);
            errors++;
            return;
         end
         e = pending.pop_front();
         compare("status", e.status, got.status);
         compare("best_bid_price", e.bid, got.bid);
         compare("best_ask_price", e.ask, got.ask);
         compare("best_bid_volume", e.bid_vol, got.bid_vol);
         compare("best_ask_volume", e.ask_vol, got.ask_vol);
         compare("spread_ticks", e.spread, got.spread);
      endfunction
   endclass

   localparam longint CYCLE_LIMIT = 20_000_000;
   localparam int     FILL_PRICE  = 32'h1000_0000;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [1:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;

   book_scoreboard book;
   int             tx_idle_pct;
   int             rx_idle_pct;
   longint         cycles;
   bit [63:0]      ref_pool [24];
   bit [31:0]      price_pool [12];

   limit_order_book_engine i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // result side: check each accepted word, stall at random
   always @(posedge clock) begin
      book_view got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.status = status_type'(rsp_tuser);
            got.bid = rsp_tdata[31:0];
            got.ask = rsp_tdata[63:32];
            got.bid_vol = rsp_tdata[95:64];
            got.ask_vol = rsp_tdata[127:96];
            got.spread = rsp_tdata[160:128];
            book.check_result(got);
         end
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   task automatic send_order(act_type act, bit [63:0] oref, bit [63:0] nref, bit sell,
                             bit [31:0] shares, bit [31:0] price);
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {7'b0, price, shares, sell, nref, oref};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      book.note_order(act, oref, nref, sell, shares, price);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   function automatic bit [63:0] pick_ref();
      if ($urandom_range(99) < 5) return {$urandom, $urandom};
      return ref_pool[$urandom_range(23)];
   endfunction

   function automatic bit [31:0] pick_shares();
      int r;
      r = $urandom_range(99);
      if (r < 5) return 0;
      if (r < 15) return $urandom;
      if (r < 18) return 32'hFFFF_FFFF;
      return $urandom_range(1, 500);
   endfunction

   function automatic bit [31:0] pick_price();
      int r;
      r = $urandom_range(99);
      if (r < 2) return 0;
      if (r < 4) return 32'hFFFF_FFFF;
      if (r < 9) return $urandom;
      return price_pool[$urandom_range(11)];
   endfunction

   task automatic run_random(int count);
      int r;
      act_type act;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(99);
         act = (r < 40) ? ACT_ADD : (r < 65) ? ACT_REDUCE : (r < 80) ? ACT_DELETE : ACT_REPLACE;
         send_order(act, pick_ref(), pick_ref(), $urandom_range(1), pick_shares(),
                    pick_price());
      end
   endtask

   initial begin
      book = new();
      cycles = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = ACT_ADD;
      rsp_tready = 1'b0;
      tx_idle_pct = 18;
      rx_idle_pct = 52;
      for (int i = 0; i < 24; i++)
         ref_pool[i] = (i < 20) ? 64'd100 + i : {$urandom, $urandom};
      ref_pool[20] = 64'hFFFF_FFFF_FFFF_FFFF;
      ref_pool[21] = 64'd0;
      for (int i = 0; i < 12; i++) price_pool[i] = 32'd10000 + 100 * i;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty book, extremes, saturation, crossed book, error codes
      send_order(ACT_DELETE, 64'd5, 64'd0, 1'b0, 0, 0);
      send_order(ACT_REDUCE, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 1'b0, 1, 0);
      send_order(ACT_REPLACE, 64'd7, 64'd8, 1'b0, 10, 10);
      send_order(ACT_ADD, 64'd1, 64'd0, 1'b0, 100, 32'd20000);
      send_order(ACT_ADD, 64'd1, 64'd0, 1'b1, 100, 32'd30000);
      send_order(ACT_ADD, 64'd2, 64'd0, 1'b1, 50, 32'd25000);
      send_order(ACT_ADD, 64'd3, 64'd0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_order(ACT_ADD, 64'd4, 64'd0, 1'b0, 32'hFFFF_FFFF, 32'd20000);
      send_order(ACT_REDUCE, 64'd1, 64'd0, 1'b0, 30, 0);
      send_order(ACT_REDUCE, 64'd4, 64'd0, 1'b0, 32'hFFFF_FFFF, 0);
      send_order(ACT_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 1'b0, 0, 32'd40000);
      send_order(ACT_REDUCE, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 1'b0, 0, 0);
      send_order(ACT_ADD, 64'd6, 64'd0, 1'b0, 5, 32'hFFFF_FFFF);
      send_order(ACT_ADD, 64'd9, 64'd0, 1'b1, 7, 32'd0);
      send_order(ACT_REPLACE, 64'd6, 64'd2, 1'b1, 9, 32'd15000);
      send_order(ACT_REPLACE, 64'd9, 64'hAAAA_5555_AAAA_5555, 1'b0, 11, 32'd26000);
      send_order(ACT_DELETE, 64'd3, 64'd0, 1'b0, 0, 0);
      send_order(ACT_DELETE, 64'd2, 64'd0, 1'b0, 0, 0);
      send_order(ACT_DELETE, 64'd1, 64'd0, 1'b0, 0, 0);
      send_order(ACT_DELETE, 64'hAAAA_5555_AAAA_5555, 64'd0, 1'b0, 0, 0);

      run_random(80);
      tx_idle_pct = 52;
      rx_idle_pct = 18;

      // run the level table out of free slots with distinct sell prices
      for (int i = 0; i < 262; i++)
         send_order(ACT_ADD, 64'hF000_0000_0000_0000 + i, 64'd0, 1'b1,
                    $urandom_range(1, 1000), FILL_PRICE + 7 * i);
      tx_idle_pct = 0;
      rx_idle_pct = 0;

      // then the order table, resting on levels that already exist
      for (int i = 0; i < 790; i++)
         send_order(ACT_ADD, 64'hE000_0000_0000_0000 + i, 64'd0, 1'b1,
                    $urandom_range(1, 1000), FILL_PRICE + 7 * $urandom_range(0, 199));
      run_random(20);
      req_tvalid <= 1'b0;

      while (book.pending.size() != 0) @(posedge clock);
      repeat (4000) @(posedge clock);
      if (book.errors == 0 && book.pending.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire

// File: files.f
rtl/lob_pkg.sv
rtl/lob_front.sv
rtl/lob_engine.sv
rtl/limit_order_book_engine.sv
bench/tb_limit_order_book_engine.sv
